FILE: rtl/linear_prime_sieve_macros.svh
// assertion macros shared by the linear prime sieve rtl
`ifndef LINEAR_PRIME_SIEVE_MACROS_SVH
`define LINEAR_PRIME_SIEVE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LPS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lps_pkg.sv
// shared constants, types and microcode rom of the linear prime sieve
package lps_pkg;

  // sizing
  localparam int MAX_NUMBER = 131072;
  localparam int MAX_PRIMES = 16384;
  localparam int CAND_W     = 17;
  localparam int COUNT_W    = 15;
  localparam int MAP_AW     = $clog2(MAX_NUMBER);
  localparam int LIST_AW    = $clog2(MAX_PRIMES);
  localparam int TOTAL_W    = $clog2(MAX_PRIMES + 1);
  localparam int PROD_W     = 2 * CAND_W;
  localparam int DIV_CNT_W  = $clog2(CAND_W);
  localparam int STEP_W     = 4;

  localparam logic [CAND_W-1:0] FIRST_CANDIDATE = CAND_W'(2);
  localparam logic [CAND_W-1:0] LIMIT_RESET     = CAND_W'(100000);

  // result status codes
  typedef enum logic [1:0] {
    ST_OK,
    ST_ORDER,
    ST_RANGE,
    ST_FULL
  } status_t;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_CLEAR,
    OP_ACCEPT,
    OP_CLASSIFY,
    OP_LIST_READ,
    OP_MULTIPLY,
    OP_MARK,
    OP_DIV_STEP,
    OP_NEXT,
    OP_RESULT
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_CLEAR_LAST,
    C_ACCEPT,
    C_ERROR,
    C_WALK_END,
    C_OVER_LIMIT,
    C_DIV_MORE,
    C_DIVIDES,
    C_OUT_FREE,
    C_ALWAYS
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  // program addresses
  localparam step_t STEP_CLEAR    = step_t'(0);
  localparam step_t STEP_WAIT     = step_t'(1);
  localparam step_t STEP_CLASSIFY = step_t'(2);
  localparam step_t STEP_LIST_RD  = step_t'(3);
  localparam step_t STEP_MULTIPLY = step_t'(4);
  localparam step_t STEP_MARK     = step_t'(5);
  localparam step_t STEP_DIV      = step_t'(6);
  localparam step_t STEP_NEXT     = step_t'(7);
  localparam step_t STEP_RESULT   = step_t'(8);

  // status from the datapath to the sequencer
  typedef struct packed {
    logic clear_last;
    logic accept;
    logic error;
    logic walk_end;
    logic over_limit;
    logic div_more;
    logic divides;
    logic out_free;
  } flags_t;

  // control word: operation, condition, target when true, target when false
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jt;
    step_t jf;
  } ucode_t;

  // microcode program
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    unique case (s)
      STEP_CLEAR:    w = '{op: OP_CLEAR,     cond: C_CLEAR_LAST, jt: STEP_WAIT,
                           jf: STEP_CLEAR};
      STEP_WAIT:     w = '{op: OP_ACCEPT,    cond: C_ACCEPT,     jt: STEP_CLASSIFY,
                           jf: STEP_WAIT};
      STEP_CLASSIFY: w = '{op: OP_CLASSIFY,  cond: C_ERROR,      jt: STEP_RESULT,
                           jf: STEP_LIST_RD};
      STEP_LIST_RD:  w = '{op: OP_LIST_READ, cond: C_WALK_END,   jt: STEP_RESULT,
                           jf: STEP_MULTIPLY};
      STEP_MULTIPLY: w = '{op: OP_MULTIPLY,  cond: C_ALWAYS,     jt: STEP_MARK,
                           jf: STEP_MARK};
      STEP_MARK:     w = '{op: OP_MARK,      cond: C_OVER_LIMIT, jt: STEP_RESULT,
                           jf: STEP_DIV};
      STEP_DIV:      w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,   jt: STEP_DIV,
                           jf: STEP_NEXT};
      STEP_NEXT:     w = '{op: OP_NEXT,      cond: C_DIVIDES,    jt: STEP_RESULT,
                           jf: STEP_LIST_RD};
      STEP_RESULT:   w = '{op: OP_RESULT,    cond: C_OUT_FREE,   jt: STEP_WAIT,
                           jf: STEP_RESULT};
      default:       w = '{op: OP_RESULT,    cond: C_ALWAYS,     jt: STEP_WAIT,
                           jf: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/lps_ram.sv
// generic single-write, single-read ram with registered read data
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lps_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
module lps_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  lps_pkg::flags_t flags,
  output lps_pkg::op_t    op
);
  import lps_pkg::*;

  `include "linear_prime_sieve_macros.svh"

  step_t  step_r;
  step_t  step_nxt;
  ucode_t word;
  logic   cond_true;

  // fetch control word
  assign word = ucode_rom(step_r);
  assign op   = word.op;

  // evaluate jump condition
  always_comb begin
    unique case (word.cond)
      C_CLEAR_LAST: cond_true = flags.clear_last;
      C_ACCEPT:     cond_true = flags.accept;
      C_ERROR:      cond_true = flags.error;
      C_WALK_END:   cond_true = flags.walk_end;
      C_OVER_LIMIT: cond_true = flags.over_limit;
      C_DIV_MORE:   cond_true = flags.div_more;
      C_DIVIDES:    cond_true = flags.divides;
      C_OUT_FREE:   cond_true = flags.out_free;
      C_ALWAYS:     cond_true = 1'b1;
      default:      cond_true = 1'b1;
    endcase
  end

  assign step_nxt = cond_true ? word.jt : word.jf;

  // step counter, starts with the map clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

  `LPS_ASSERT_NEXT(a_accept_to_classify, op == OP_ACCEPT && flags.accept, op == OP_CLASSIFY, "accepted item not classified next cycle")
  `LPS_ASSERT_IMPL(a_wait_after_result, step_r == STEP_RESULT && flags.out_free, step_nxt == STEP_WAIT, "result taken but sequencer not returning to wait")

endmodule

FILE: rtl/lps_dp.sv
// sieve datapath: composite map, prime list, multiplier and serial divider
module lps_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lps_pkg::op_t                op,
  input  logic                        in_valid,
  input  logic [lps_pkg::CAND_W-1:0]  in_candidate,
  input  logic [lps_pkg::CAND_W-1:0]  limit,
  input  logic                        out_free,
  output lps_pkg::flags_t             flags,
  output logic                        res_prime,
  output logic [lps_pkg::COUNT_W-1:0] res_count,
  output lps_pkg::status_t            res_status
);
  import lps_pkg::*;

  `include "linear_prime_sieve_macros.svh"

  logic [MAP_AW-1:0]    clr_addr_r;
  logic [CAND_W-1:0]    cand_r;
  logic [CAND_W-1:0]    expected_r;
  status_t              status_r;
  logic                 prime_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [TOTAL_W-1:0]   k_r;
  logic [CAND_W-1:0]    p_r;
  logic [PROD_W-1:0]    prod_r;
  logic [CAND_W-1:0]    rem_r;
  logic [CAND_W-1:0]    rem_nxt;
  logic [CAND_W-1:0]    dvd_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic                 map_we;
  logic [MAP_AW-1:0]    map_waddr;
  logic                 map_q;
  logic                 list_we;
  logic [CAND_W-1:0]    list_q;

  logic                 in_order_err;
  logic                 in_range_err;
  logic                 list_full;
  logic                 is_new_prime;
  logic                 over_limit;
  logic [CAND_W:0]      trial;
  logic                 trial_ge;

  // composite map: cleared entry by entry after reset, then marked
  assign map_we    = (op == OP_CLEAR) || (op == OP_MARK && !over_limit);
  assign map_waddr = (op == OP_CLEAR) ? clr_addr_r : prod_r[MAP_AW-1:0];

  lps_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NUMBER)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (op != OP_CLEAR),
    .raddr (MAP_AW'(in_candidate)),
    .rdata (map_q)
  );

  // prime list: appended at classify, read in walk order
  assign list_we = (op == OP_CLASSIFY) && is_new_prime;

  lps_ram #(
    .WIDTH (CAND_W),
    .DEPTH (MAX_PRIMES)
  ) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (total_r[LIST_AW-1:0]),
    .wdata (cand_r),
    .raddr (k_r[LIST_AW-1:0]),
    .rdata (list_q)
  );

  // input checks at accept
  assign in_order_err = in_candidate != expected_r;
  assign in_range_err = (in_candidate < FIRST_CANDIDATE) || (in_candidate > limit) ||
                        (32'(in_candidate) >= 32'(MAX_NUMBER));

  // classification from the map read
  assign list_full    = total_r == TOTAL_W'(MAX_PRIMES);
  assign is_new_prime = (status_r == ST_OK) && !map_q && !list_full;

  // product bound against the active limit
  assign over_limit = (prod_r > PROD_W'(limit)) || (prod_r >= PROD_W'(MAX_NUMBER));

  // one restoring division step for the remainder
  assign trial    = {rem_r, dvd_r[CAND_W-1]};
  assign trial_ge = trial >= {1'b0, p_r};
  assign rem_nxt  = trial_ge ? CAND_W'(trial - {1'b0, p_r}) : trial[CAND_W-1:0];

  // flags for the sequencer
  assign flags.clear_last = clr_addr_r == MAP_AW'(MAX_NUMBER - 1);
  assign flags.accept     = in_valid;
  assign flags.error      = (status_r != ST_OK) || (!map_q && list_full);
  assign flags.walk_end   = k_r >= total_r;
  assign flags.over_limit = over_limit;
  assign flags.div_more   = cnt_r != DIV_CNT_W'(CAND_W - 1);
  assign flags.divides    = rem_r == '0;
  assign flags.out_free   = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      expected_r <= FIRST_CANDIDATE;
      total_r    <= '0;
    end else begin
      if (op == OP_CLEAR) begin
        clr_addr_r <= clr_addr_r + MAP_AW'(1);
      end
      if (op == OP_CLASSIFY && is_new_prime) begin
        total_r <= total_r + TOTAL_W'(1);
      end
      if (op == OP_RESULT && out_free && status_r == ST_OK) begin
        expected_r <= cand_r + CAND_W'(1);
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_ACCEPT: begin
        if (in_valid) begin
          cand_r <= in_candidate;
          if (in_order_err) begin
            status_r <= ST_ORDER;
          end else if (in_range_err) begin
            status_r <= ST_RANGE;
          end else begin
            status_r <= ST_OK;
          end
        end
      end
      OP_CLASSIFY: begin
        prime_r <= is_new_prime;
        k_r     <= '0;
        if (status_r == ST_OK && !map_q && list_full) begin
          status_r <= ST_FULL;
        end
      end
      OP_MULTIPLY: begin
        p_r    <= list_q;
        prod_r <= PROD_W'(list_q) * PROD_W'(cand_r);
      end
      OP_MARK: begin
        rem_r <= '0;
        dvd_r <= cand_r;
        cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
      OP_NEXT: begin
        k_r <= k_r + TOTAL_W'(1);
      end
      default: begin
      end
    endcase
  end

  // result fields
  assign res_prime  = prime_r;
  assign res_count  = COUNT_W'(total_r);
  assign res_status = status_r;

  `LPS_ASSERT_IMPL(a_total_bound, 1'b1, total_r <= TOTAL_W'(MAX_PRIMES), "prime count above list depth")
  `LPS_ASSERT_IMPL(a_mark_above_cand, op == OP_MARK && !over_limit, prod_r > PROD_W'(cand_r), "marking at or below the candidate")
  `LPS_ASSERT_NEXT(a_rem_below_divisor, op == OP_DIV_STEP, rem_r < p_r, "partial remainder not below divisor")

endmodule

FILE: rtl/linear_prime_sieve.sv
// linear prime sieve top level: limit register, output register, sequencer and datapath
// per item: accept and classify; unless in error, walk the prime list (registered read):
// read a prime, multiply and mark the product unless it passes the limit, which ends the
// walk; else a serial remainder unit divides by it, and a divisor or the list end ends it
// a new item is accepted while the previous result still waits in the output register
// reset: a clearing pass over all 131072 entries of the composite map, no item accepted meanwhile
module linear_prime_sieve (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lps_pkg::CAND_W-1:0]  in_candidate,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_prime,
  output logic [lps_pkg::COUNT_W-1:0] out_primes_found,
  output logic [1:0]                  out_status,
  input  logic                        cfg_wr_en,
  input  logic [lps_pkg::CAND_W-1:0]  cfg_wr_data
);
  import lps_pkg::*;

  logic [CAND_W-1:0]  limit_r;
  logic               out_valid_r;
  logic               out_is_prime_r;
  logic [COUNT_W-1:0] out_count_r;
  status_t            out_status_r;

  op_t                op;
  flags_t             flags;
  logic               out_free;
  logic               res_prime;
  logic [COUNT_W-1:0] res_count;
  status_t            res_status;

  // sieve limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  lps_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  lps_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .in_valid     (in_valid),
    .in_candidate (in_candidate),
    .limit        (limit_r),
    .out_free     (out_free),
    .flags        (flags),
    .res_prime    (res_prime),
    .res_count    (res_count),
    .res_status   (res_status)
  );

  assign in_ready = op == OP_ACCEPT;
  assign out_free = !out_valid_r || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_RESULT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_RESULT && out_free) begin
      out_is_prime_r <= res_prime;
      out_count_r    <= res_count;
      out_status_r   <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_prime     = out_is_prime_r;
  assign out_primes_found = out_count_r;
  assign out_status       = out_status_r;

endmodule
